[rtl/core/shpq_pkg.sv]
package shpq_pkg;

   // field widths
   localparam int SAMPLE_WIDTH  = 16;
   localparam int HISTORY_DEPTH = 3;
   localparam int POS_WIDTH     = 2;
   localparam int RUN_WIDTH     = 4;
   localparam int FRAMES_WIDTH  = 4;
   localparam int MS_IN_WIDTH   = 10;
   localparam int MS_WIDTH      = 16;
   localparam int EVENT_WIDTH   = 2;

   // configuration port
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = SAMPLE_WIDTH;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ENABLE            = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PRESS_THRESHOLD   = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RELEASE_THRESHOLD = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CONFIRM_RUNS      = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEBOUNCE_MS       = 3'd4;

   // event codes
   localparam logic [EVENT_WIDTH-1:0] EVENT_NONE    = 2'd0;
   localparam logic [EVENT_WIDTH-1:0] EVENT_PRESS   = 2'd1;
   localparam logic [EVENT_WIDTH-1:0] EVENT_RELEASE = 2'd2;

   localparam logic [RUN_WIDTH-1:0] RUN_MAX = '1;
   localparam logic [MS_WIDTH-1:0]  MS_MAX  = '1;

   // register reset values
   localparam logic                           ENABLE_RESET    = 1'b1;
   localparam logic signed [SAMPLE_WIDTH-1:0] PRESS_RESET     = 16'sd16384;
   localparam logic signed [SAMPLE_WIDTH-1:0] RELEASE_RESET   = 16'sd13107;
   localparam logic [FRAMES_WIDTH-1:0]        FRAMES_RESET    = 4'd2;
   localparam logic [MS_IN_WIDTH-1:0]         DEBOUNCE_RESET  = 10'd50;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] sample;
      logic                           sample_valid;
      logic [MS_IN_WIDTH-1:0]         elapsed_ms;
   } req_type;

   typedef struct packed {
      logic [EVENT_WIDTH-1:0]         event_res;
      logic                           pressed;
      logic signed [SAMPLE_WIDTH-1:0] smoothed;
      logic signed [SAMPLE_WIDTH-1:0] held_value;
   } rsp_type;

   typedef struct packed {
      logic                           enable;
      logic signed [SAMPLE_WIDTH-1:0] press_threshold;
      logic signed [SAMPLE_WIDTH-1:0] release_threshold;
      logic [FRAMES_WIDTH-1:0]        confirm_runs;
      logic [MS_IN_WIDTH-1:0]         debounce_ms;
   } cfg_type;

endpackage

[rtl/core/shpq_avg3.sv]
module shpq_avg3 (
   input  logic signed [shpq_pkg::SAMPLE_WIDTH-1:0] a,
   input  logic signed [shpq_pkg::SAMPLE_WIDTH-1:0] b,
   input  logic signed [shpq_pkg::SAMPLE_WIDTH-1:0] c,
   output logic signed [shpq_pkg::SAMPLE_WIDTH-1:0] avg
);

   localparam int SW        = shpq_pkg::SAMPLE_WIDTH;
   localparam int SUM_WIDTH = SW + 2;
   localparam int MAG_WIDTH = SW + 1;
   // reciprocal of three, exact for every magnitude that three samples reach
   localparam int SHIFT     = SW + 2;
   localparam int RCP_WIDTH = SHIFT - 1;
   localparam logic [RCP_WIDTH-1:0] RECIP = RCP_WIDTH'(((64'd1 << SHIFT) + 64'd2) / 64'd3);
   localparam int PROD_WIDTH = MAG_WIDTH + RCP_WIDTH;

   logic signed [SUM_WIDTH-1:0] sum;
   logic                        neg;
   logic [SUM_WIDTH-1:0]        sum_abs;
   logic [MAG_WIDTH-1:0]        mag;
   logic [PROD_WIDTH-1:0]       prod;
   logic [SW-1:0]               quot;

   always_comb begin
      sum     = SUM_WIDTH'(a) + SUM_WIDTH'(b) + SUM_WIDTH'(c);
      neg     = sum[SUM_WIDTH-1];
      sum_abs = neg ? SUM_WIDTH'(-sum) : SUM_WIDTH'(sum);
      mag     = sum_abs[MAG_WIDTH-1:0];
      prod    = PROD_WIDTH'(mag) * PROD_WIDTH'(RECIP);
      quot    = prod[SHIFT +: SW];
      // truncation toward zero: divide the magnitude, then restore the sign
      avg     = neg ? $signed(~quot + 1'b1) : $signed(quot);
   end

endmodule

[rtl/core/shpq_core.sv]
module shpq_core (
   input  logic              clock,
   input  logic              reset,
   input  shpq_pkg::cfg_type cfg,
   input  shpq_pkg::req_type item,
   input  logic              fire,
   output shpq_pkg::rsp_type result
);

   localparam int SW = shpq_pkg::SAMPLE_WIDTH;
   localparam int HD = shpq_pkg::HISTORY_DEPTH;
   localparam int PW = shpq_pkg::POS_WIDTH;

   logic signed [SW-1:0]                hist_ff [HD];
   logic signed [SW-1:0]                hist_in [HD];
   logic [PW-1:0]                       pos_ff, pos_in;
   logic                                pending_ff, pending_in;
   logic [shpq_pkg::RUN_WIDTH-1:0]      run_ff, run_in;
   logic                                pressed_ff, pressed_in;
   logic signed [SW-1:0]                last_ff, last_in;
   logic [shpq_pkg::MS_WIDTH-1:0]       ms_ff, ms_in;

   logic signed [SW-1:0]                value;
   logic signed [SW-1:0]                avg_src [HD];
   logic signed [SW-1:0]                smooth;
   logic signed [SW-1:0]                thr;
   logic [shpq_pkg::MS_WIDTH:0]         ms_sum;
   logic [shpq_pkg::MS_WIDTH-1:0]       ms_adv;
   logic [shpq_pkg::RUN_WIDTH-1:0]      run_inc;
   logic                                level;
   logic                                validated;
   logic                                change;
   logic [shpq_pkg::EVENT_WIDTH-1:0]    event_code;

   // history with the new sample written in while enabled
   always_comb begin
      value = item.sample_valid ? item.sample : '0;
      for (int i = 0; i < HD; i++) begin
         hist_in[i] = hist_ff[i];
         if (cfg.enable && pos_ff == PW'(i)) begin
            hist_in[i] = value;
         end
         avg_src[i] = hist_in[i];
      end
   end

   shpq_avg3 u_avg (
      .a   (avg_src[0]),
      .b   (avg_src[1]),
      .c   (avg_src[2]),
      .avg (smooth)
   );

   always_comb begin
      // timer runs even while disabled
      ms_sum = {1'b0, ms_ff} + (shpq_pkg::MS_WIDTH + 1)'(item.elapsed_ms);
      ms_adv = ms_sum[shpq_pkg::MS_WIDTH] ? shpq_pkg::MS_MAX : ms_sum[shpq_pkg::MS_WIDTH-1:0];

      thr   = pressed_ff ? cfg.release_threshold : cfg.press_threshold;
      level = smooth >= thr;

      run_inc   = (run_ff == shpq_pkg::RUN_MAX) ? run_ff : run_ff + 1'b1;
      validated = (level == pending_ff) && (run_inc >= cfg.confirm_runs);
      change    = validated && (level != pressed_ff)
                  && (ms_adv >= shpq_pkg::MS_WIDTH'(cfg.debounce_ms));

      pos_in     = pos_ff;
      pending_in = pending_ff;
      run_in     = run_ff;
      pressed_in = pressed_ff;
      last_in    = last_ff;
      ms_in      = ms_adv;
      event_code = shpq_pkg::EVENT_NONE;

      if (cfg.enable) begin
         pos_in = (pos_ff == PW'(HD - 1)) ? '0 : pos_ff + 1'b1;
         if (level == pending_ff) begin
            run_in = run_inc;
         end else begin
            pending_in = level;
            run_in     = shpq_pkg::RUN_WIDTH'(1);
         end
         if (change) begin
            pressed_in = level;
            ms_in      = '0;
            event_code = level ? shpq_pkg::EVENT_PRESS : shpq_pkg::EVENT_RELEASE;
         end
         if (change || pressed_in) begin
            last_in = smooth;
         end
      end

      result.event_res  = event_code;
      result.pressed    = pressed_in;
      result.smoothed   = smooth;
      result.held_value = last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HD; i++) begin
            hist_ff[i] <= '0;
         end
         pos_ff     <= '0;
         pending_ff <= 1'b0;
         run_ff     <= '0;
         pressed_ff <= 1'b0;
         last_ff    <= '0;
         ms_ff      <= '0;
      end else if (fire) begin
         for (int i = 0; i < HD; i++) begin
            hist_ff[i] <= hist_in[i];
         end
         pos_ff     <= pos_in;
         pending_ff <= pending_in;
         run_ff     <= run_in;
         pressed_ff <= pressed_in;
         last_ff    <= last_in;
         ms_ff      <= ms_in;
      end
   end

endmodule

[rtl/core/smoothed_hysteresis_press_qualifier.sv]
// Press qualifier for one analog axis. Each transfer on req carries a signed
// Q1.15 sample, a validity flag (an invalid sample counts as zero) and the
// milliseconds since the previous frame; each produces exactly one transfer on
// rsp with the event (none, press, release), the qualified pressed state, the
// three-sample average (truncated toward zero) and the value held while
// pressed. The level is compared with the press threshold while released and
// with the release threshold while pressed; a change is taken only after
// confirm_runs equal levels in a row and once debounce_ms has passed
// since the previous change. With enable low the sample is ignored but the
// millisecond timer still runs. Throughput is one item per clock while the result
// side does not stall: the item is registered, then the average, compares and
// state update are computed combinationally into the result register, which
// drives rsp_valid. The input register keeps taking items while a result waits,
// and stalls only when both it and the result register hold items and rsp_stall
// is high. The user must write registers through the csr port only while the
// block is idle; the block itself does not enforce this. After reset they
// hold enable 1, press 16384, release 13107, confirm runs 2, debounce 50 ms.
module smoothed_hysteresis_press_qualifier (
   input  logic                                     clock,
   input  logic                                     reset,
   // input channel
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  shpq_pkg::req_type                        req_data,
   // result channel
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output shpq_pkg::rsp_type                        rsp_data,
   // register writes
   input  logic                                     csr_we,
   input  logic [shpq_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [shpq_pkg::CSR_DATA_WIDTH-1:0]      csr_wdata
);

   shpq_pkg::cfg_type cfg_ff;

   // input register
   logic              in_valid_ff;
   shpq_pkg::req_type in_data_ff;

   // result register
   logic              out_valid_ff;
   shpq_pkg::rsp_type out_data_ff;
   shpq_pkg::rsp_type result;

   logic              advance;
   logic              req_take;

   // the registered item moves on when the result register is free or emptying
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // configuration registers, writes beyond the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable            <= shpq_pkg::ENABLE_RESET;
         cfg_ff.press_threshold   <= shpq_pkg::PRESS_RESET;
         cfg_ff.release_threshold <= shpq_pkg::RELEASE_RESET;
         cfg_ff.confirm_runs      <= shpq_pkg::FRAMES_RESET;
         cfg_ff.debounce_ms       <= shpq_pkg::DEBOUNCE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            shpq_pkg::CSR_ENABLE: begin
               cfg_ff.enable <= csr_wdata[0];
            end
            shpq_pkg::CSR_PRESS_THRESHOLD: begin
               cfg_ff.press_threshold <= $signed(csr_wdata[shpq_pkg::SAMPLE_WIDTH-1:0]);
            end
            shpq_pkg::CSR_RELEASE_THRESHOLD: begin
               cfg_ff.release_threshold <= $signed(csr_wdata[shpq_pkg::SAMPLE_WIDTH-1:0]);
            end
            shpq_pkg::CSR_CONFIRM_RUNS: begin
               cfg_ff.confirm_runs <= csr_wdata[shpq_pkg::FRAMES_WIDTH-1:0];
            end
            shpq_pkg::CSR_DEBOUNCE_MS: begin
               cfg_ff.debounce_ms <= csr_wdata[shpq_pkg::MS_IN_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // average, hysteresis and qualification state
   shpq_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .item   (in_data_ff),
      .fire   (advance),
      .result (result)
   );

   // pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= result;
      end
   end

   // a press event always leaves the input pressed
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff.event_res == shpq_pkg::EVENT_PRESS |-> out_data_ff.pressed)
      else $error("press event without pressed state");

   // a release event always leaves the input released
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff.event_res == shpq_pkg::EVENT_RELEASE |-> !out_data_ff.pressed)
      else $error("release event with pressed state");

   // while pressed the held value tracks the average
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff.pressed |-> out_data_ff.held_value == out_data_ff.smoothed)
      else $error("held value differs from average while pressed");

   // the input side only stalls with a registered item waiting on a full result
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff && rsp_stall)
      else $error("input stalled without back-pressure");

endmodule

[dv/press_qualifier_checker.sv]
`timescale 1ns / 1ps

module press_qualifier_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  shpq_pkg::req_type                    req_data,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  shpq_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_we,
   input  logic [shpq_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [shpq_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   output int                                   mismatch_count,
   output int                                   frames_in_flight
);

   shpq_pkg::cfg_type                        cfg;
   logic signed [shpq_pkg::SAMPLE_WIDTH-1:0] window [shpq_pkg::HISTORY_DEPTH];
   int unsigned                              slot;
   logic                                     level_seen;
   logic [shpq_pkg::RUN_WIDTH-1:0]           run_len;
   logic                                     is_pressed;
   logic signed [shpq_pkg::SAMPLE_WIDTH-1:0] held;
   logic [shpq_pkg::MS_WIDTH-1:0]            ms_timer;
   shpq_pkg::rsp_type                        qualified_frames [$];
   int                                       fault_total = 0;

   // sum of the window divided by its depth, truncated toward zero
   function automatic logic signed [shpq_pkg::SAMPLE_WIDTH-1:0] window_mean();
      int sum;
      sum = 0;
      for (int i = 0; i < shpq_pkg::HISTORY_DEPTH; i++) begin
         sum += int'(window[i]);
      end
      return shpq_pkg::SAMPLE_WIDTH'(sum / shpq_pkg::HISTORY_DEPTH);
   endfunction

   function automatic shpq_pkg::rsp_type qualify_frame(shpq_pkg::req_type f);
      shpq_pkg::rsp_type                        r;
      int unsigned                              t;
      logic signed [shpq_pkg::SAMPLE_WIDTH-1:0] mean;
      logic signed [shpq_pkg::SAMPLE_WIDTH-1:0] bar;
      logic                                     level;
      logic                                     validated;
      r.event_res = shpq_pkg::EVENT_NONE;
      // the timer runs whether or not the block is enabled
      t = 32'(ms_timer) + 32'(f.elapsed_ms);
      ms_timer = (t > shpq_pkg::MS_MAX) ? shpq_pkg::MS_MAX : t[shpq_pkg::MS_WIDTH-1:0];
      if (cfg.enable) begin
         window[slot] = f.sample_valid ? f.sample : '0;
         slot = (slot + 1) % shpq_pkg::HISTORY_DEPTH;
         mean = window_mean();
         bar = is_pressed ? $signed(cfg.release_threshold) : $signed(cfg.press_threshold);
         level = (mean >= bar);
         if (level == level_seen) begin
            if (run_len != shpq_pkg::RUN_MAX) begin
               run_len = run_len + 1'b1;
            end
            validated = (run_len >= cfg.confirm_runs);
         end else begin
            level_seen = level;
            run_len = shpq_pkg::RUN_WIDTH'(1);
            validated = 1'b0;
         end
         if (validated && level != is_pressed
             && ms_timer >= shpq_pkg::MS_WIDTH'(cfg.debounce_ms)) begin
            is_pressed = level;
            held = mean;
            ms_timer = '0;
            r.event_res = level ? shpq_pkg::EVENT_PRESS : shpq_pkg::EVENT_RELEASE;
         end
         if (is_pressed) begin
            held = mean;
         end
      end else begin
         mean = window_mean();
      end
      r.pressed = is_pressed;
      r.smoothed = mean;
      r.held_value = held;
      return r;
   endfunction

   task automatic compare_field(input string name,
                                input logic [shpq_pkg::SAMPLE_WIDTH-1:0] want,
                                input logic [shpq_pkg::SAMPLE_WIDTH-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
         fault_total++;
      end
   endtask

   always @(posedge clock) begin
      shpq_pkg::rsp_type want;
      if (reset) begin
         cfg.enable = shpq_pkg::ENABLE_RESET;
         cfg.press_threshold = shpq_pkg::PRESS_RESET;
         cfg.release_threshold = shpq_pkg::RELEASE_RESET;
         cfg.confirm_runs = shpq_pkg::FRAMES_RESET;
         cfg.debounce_ms = shpq_pkg::DEBOUNCE_RESET;
         foreach (window[i]) begin
            window[i] = '0;
         end
         slot = 0;
         level_seen = 1'b0;
         run_len = '0;
         is_pressed = 1'b0;
         held = '0;
         ms_timer = '0;
         qualified_frames.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               shpq_pkg::CSR_ENABLE:
                  cfg.enable = csr_wdata[0];
               shpq_pkg::CSR_PRESS_THRESHOLD:
                  cfg.press_threshold = csr_wdata;
               shpq_pkg::CSR_RELEASE_THRESHOLD:
                  cfg.release_threshold = csr_wdata;
               shpq_pkg::CSR_CONFIRM_RUNS:
                  cfg.confirm_runs = csr_wdata[shpq_pkg::FRAMES_WIDTH-1:0];
               shpq_pkg::CSR_DEBOUNCE_MS:
                  cfg.debounce_ms = csr_wdata[shpq_pkg::MS_IN_WIDTH-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            qualified_frames.push_back(qualify_frame(req_data));
         end
         if (rsp_valid && !rsp_stall) begin
            if (qualified_frames.size() == 0) begin
               $error("result transfer with no frame outstanding: %h", rsp_data);
               fault_total++;
            end else begin
               want = qualified_frames.pop_front();
               compare_field("event_res", shpq_pkg::SAMPLE_WIDTH'(want.event_res),
                             shpq_pkg::SAMPLE_WIDTH'(rsp_data.event_res));
               compare_field("pressed", shpq_pkg::SAMPLE_WIDTH'(want.pressed),
                             shpq_pkg::SAMPLE_WIDTH'(rsp_data.pressed));
               compare_field("smoothed", want.smoothed, rsp_data.smoothed);
               compare_field("held_value", want.held_value, rsp_data.held_value);
            end
         end
      end
      mismatch_count <= fault_total;
      frames_in_flight <= qualified_frames.size();
   end

endmodule

[dv/smoothed_hysteresis_press_qualifier_test.sv]
`timescale 1ns / 1ps

module smoothed_hysteresis_press_qualifier_test;

   localparam int PERIOD_NS        = 8;
   localparam int SETTLE_CYCLES    = 8;     // pipeline is two deep, leave a margin
   localparam int RANDOM_PHASES    = 9;
   localparam int FRAMES_PER_PHASE = 80;
   // roughly 850 frames are sent in all; the limit is set well above the time they take
   localparam int LIMIT_NS         = 2_000_000;
   localparam int REQ_BITS         = $bits(shpq_pkg::req_type);

   logic                                 clock;
   logic                                 reset;
   logic                                 req_valid;
   logic                                 req_stall;
   shpq_pkg::req_type                    req_data;
   logic                                 rsp_valid;
   logic                                 rsp_stall;
   shpq_pkg::rsp_type                    rsp_data;
   logic                                 csr_we;
   logic [shpq_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [shpq_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata;
   int                                   mismatch_count;
   int                                   frames_in_flight;

   bit                calm;       // no gaps on either side while set
   shpq_pkg::cfg_type settings;   // what the block currently holds, used to aim the stimulus

   smoothed_hysteresis_press_qualifier dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   press_qualifier_checker qualifier_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .mismatch_count   (mismatch_count),
      .frames_in_flight (frames_in_flight)
   );

   initial begin
      clock = 1'b0;
      forever #(PERIOD_NS / 2) clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #(LIMIT_NS);
      $display("smoothed_hysteresis_press_qualifier_test: errors");
      $finish;
   end

   // result side back-pressure: random bursts of stalled cycles
   initial begin
      int burst;
      burst = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (burst > 0) begin
            burst--;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            burst = $urandom_range(1, 5);
         end
         rsp_stall <= (burst > 0);
      end
   end

   function automatic shpq_pkg::req_type frame_of(input int sample, input bit valid,
                                                  input int ms);
      shpq_pkg::req_type f;
      f.sample = shpq_pkg::SAMPLE_WIDTH'(sample);
      f.sample_valid = valid;
      f.elapsed_ms = shpq_pkg::MS_IN_WIDTH'(ms);
      return f;
   endfunction

   function automatic shpq_pkg::cfg_type settings_of(input bit en, input int press,
                                                     input int rel, input int frames,
                                                     input int debounce);
      shpq_pkg::cfg_type s;
      s.enable = en;
      s.press_threshold = shpq_pkg::SAMPLE_WIDTH'(press);
      s.release_threshold = shpq_pkg::SAMPLE_WIDTH'(rel);
      s.confirm_runs = shpq_pkg::FRAMES_WIDTH'(frames);
      s.debounce_ms = shpq_pkg::MS_IN_WIDTH'(debounce);
      return s;
   endfunction

   // one frame transfer, maybe after an idle burst with junk on the bus
   task automatic send_frame(input shpq_pkg::req_type frame);
      int gap;
      gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         req_data  <= shpq_pkg::req_type'(REQ_BITS'($urandom));
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= frame;
      do @(posedge clock); while (req_stall);
   endtask

   // stop sending and wait until every frame has its result back
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (frames_in_flight != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [shpq_pkg::CSR_INDEX_WIDTH-1:0] index,
                            input logic [shpq_pkg::CSR_DATA_WIDTH-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
   endtask

   task automatic write_settings(input shpq_pkg::cfg_type s);
      write_reg(shpq_pkg::CSR_ENABLE, shpq_pkg::CSR_DATA_WIDTH'(s.enable));
      write_reg(shpq_pkg::CSR_PRESS_THRESHOLD, s.press_threshold);
      write_reg(shpq_pkg::CSR_RELEASE_THRESHOLD, s.release_threshold);
      write_reg(shpq_pkg::CSR_CONFIRM_RUNS, shpq_pkg::CSR_DATA_WIDTH'(s.confirm_runs));
      write_reg(shpq_pkg::CSR_DEBOUNCE_MS, shpq_pkg::CSR_DATA_WIDTH'(s.debounce_ms));
      @(negedge clock);
      csr_we <= 1'b0;
      settings = s;
   endtask

   // random settings: mostly a sane hysteresis band, sometimes anything at all
   function automatic shpq_pkg::cfg_type random_settings();
      int press;
      int rel;
      int debounce;
      if ($urandom_range(0, 3) == 0) begin
         press = int'($urandom_range(0, 65535)) - 32768;
         rel   = int'($urandom_range(0, 65535)) - 32768;
      end else begin
         press = int'($urandom_range(4000, 28000));
         rel   = press - int'($urandom_range(0, 8000));
      end
      debounce = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 120);
      return settings_of($urandom_range(0, 5) != 0, press, rel, $urandom_range(0, 15), debounce);
   endfunction

   // frames in episodes: steady runs above or below the band, runs near a
   // threshold, and plain noise; each episode has its own timing pattern
   task automatic play_phase(input int frames);
      int left;
      int len;
      int centre;
      int spread;
      int hi_bar;
      int lo_bar;
      int ms_mode;
      int ms;
      int v;
      int press;
      int rel;
      left = frames;
      while (left > 0) begin
         press  = int'($signed(settings.press_threshold));
         rel    = int'($signed(settings.release_threshold));
         hi_bar = (press > rel) ? press : rel;
         lo_bar = (press < rel) ? press : rel;
         len    = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 8);
         spread = $urandom_range(0, 3000);
         case ($urandom_range(0, 5))
            0: begin
               centre = int'($urandom_range(0, 65535)) - 32768;
               spread = 32767;
            end
            1, 2: centre = hi_bar + int'($urandom_range(0, 32767 - hi_bar));
            3, 4: begin
               if (lo_bar > -32768) begin
                  centre = -32768 + int'($urandom_range(0, lo_bar + 32767));
               end else begin
                  centre = -32768;
               end
            end
            default: begin
               centre = $urandom_range(0, 1) ? press : rel;
               spread = 300;
            end
         endcase
         ms_mode = $urandom_range(0, 3);
         for (int k = 0; k < len && left > 0; k++) begin
            v = centre + int'($urandom_range(0, 2 * spread)) - spread;
            if (v > 32767) begin
               v = 32767;
            end else if (v < -32768) begin
               v = -32768;
            end
            case (ms_mode)
               0:       ms = $urandom_range(0, 20);
               1:       ms = $urandom_range(0, 200);
               2:       ms = 1023;
               default: ms = $urandom_range(0, 1023);
            endcase
            send_frame(frame_of(v, $urandom_range(0, 11) != 0, ms));
            left--;
         end
      end
   endtask

   initial begin
      shpq_pkg::cfg_type plan;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      calm      = 1'b0;
      settings  = settings_of(shpq_pkg::ENABLE_RESET, shpq_pkg::PRESS_RESET,
                              shpq_pkg::RELEASE_RESET, shpq_pkg::FRAMES_RESET,
                              shpq_pkg::DEBOUNCE_RESET);
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed frames at the reset settings
      // full scale up, press once the run and the time allow
      send_frame(frame_of(32767, 1'b1, 0));
      send_frame(frame_of(32767, 1'b1, 0));
      send_frame(frame_of(32767, 1'b1, 1023));
      // full scale down, debounce not yet met
      send_frame(frame_of(-32768, 1'b1, 5));
      send_frame(frame_of(-32768, 1'b1, 5));
      // invalid sample counts as zero, release now due
      send_frame(frame_of(-32768, 1'b0, 1023));
      // average landing exactly on the press threshold
      send_frame(frame_of(16384, 1'b1, 0));
      send_frame(frame_of(16384, 1'b1, 0));
      send_frame(frame_of(16384, 1'b1, 1023));
      send_frame(frame_of(16384, 1'b1, 0));
      // average exactly on the release threshold keeps it pressed
      send_frame(frame_of(13107, 1'b1, 0));
      send_frame(frame_of(13107, 1'b1, 0));
      send_frame(frame_of(13107, 1'b1, 0));
      // small negatives: division truncates toward zero
      send_frame(frame_of(-1, 1'b1, 0));
      send_frame(frame_of(-1, 1'b1, 3));
      send_frame(frame_of(-2, 1'b1, 3));
      send_frame(frame_of(0, 1'b1, 40));
      // alternating bit patterns on every field
      send_frame(frame_of(21845, 1'b1, 341));
      send_frame(frame_of(-21846, 1'b0, 682));
      drain();

      // long hold: saturate the ms timer, then the run counter
      write_settings(settings_of(1'b1, 32767, 32767, 15, 1023));
      for (int k = 0; k < 65; k++) begin
         send_frame(frame_of(int'($urandom_range(0, 65534)) - 32768, $urandom_range(0, 1), 1023));
      end
      for (int k = 0; k < 18; k++) begin
         send_frame(frame_of(32767, 1'b1, 0));
      end
      for (int k = 0; k < 24; k++) begin
         send_frame(frame_of(int'($urandom_range(0, 65535)) - 32768, 1'b0, 50));
      end
      drain();

      // fixed corners first, then random settings; the last phase runs flat out
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0:       plan = settings_of(1'b1, 16384, 13107, 1, 0);
            1:       plan = settings_of(1'b1, -32768, 32767, 0, 1023);  // crossed band
            2:       plan = settings_of(1'b1, 32767, -32768, 15, 0);
            3:       plan = settings_of(1'b0, 0, 0, 0, 0);              // block off
            4:       plan = settings_of(1'b1, 0, 0, 2, 50);             // equal thresholds
            default: plan = random_settings();
         endcase
         if (p == RANDOM_PHASES - 1) begin
            plan.enable = 1'b1;
         end
         write_settings(plan);
         calm = (p == RANDOM_PHASES - 1) || ($urandom_range(0, 4) == 0);
         play_phase(FRAMES_PER_PHASE);
         drain();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && frames_in_flight == 0) begin
         $display("smoothed_hysteresis_press_qualifier_test: clean");
      end else begin
         $display("smoothed_hysteresis_press_qualifier_test: errors");
      end
      $finish;
   end

endmodule
